// ===== sv/c2w_pkg.sv =====
// c2w_pkg: shared types, widths, reset values and codes for the counter to
// wall clock converter. No dependencies; the interfaces and the top level import it.
`timescale 1ns / 1ps

package c2w_pkg;

  // Default width of the two frequency registers.
  localparam int FREQ_WIDTH_DEF = 40;

  // Field widths of the channels.
  localparam int TIME_W     = 64;
  localparam int MILLIS_W   = 51;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [TIME_W-1:0]    u64_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_PERF_HZ     = 3'd0;
  localparam cfg_idx_t REG_CYCLE_HZ    = 3'd1;
  localparam cfg_idx_t REG_PERF_START  = 3'd2;
  localparam cfg_idx_t REG_CYCLE_START = 3'd3;
  localparam cfg_idx_t REG_BASE_TIME   = 3'd4;

  // Source opcodes.
  localparam logic OP_PERF  = 1'b0;
  localparam logic OP_CYCLE = 1'b1;

  // Register reset values.
  localparam u64_t DEF_PERF_HZ     = 64'd10000000;
  localparam u64_t DEF_CYCLE_HZ    = 64'd3000000000;
  localparam u64_t DEF_PERF_START  = 64'd1000000;
  localparam u64_t DEF_CYCLE_START = 64'd0;
  localparam u64_t DEF_BASE_TIME   = 64'd133700000000000000;

  // 100 ns ticks per second, and its width.
  localparam int              SEC_W         = 24;
  localparam logic [SEC_W-1:0] TICKS_PER_SEC = 24'd10000000;

  // Division by 10^4 (100 ns ticks per millisecond) for any 64-bit x:
  // x / 10^4 = ((x >> MS_PRE_SH) * MS_RECIP) >> MS_POST_SH, where MS_RECIP is
  // 2^70 / 625 rounded up. The rounding error stays below one unit.
  localparam int                    MS_PRE_SH  = 4;
  localparam int                    MS_POST_SH = 70;
  localparam int                    MS_RECIP_W = 61;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP   = 61'd1888946593147858086;

  // Unix epoch in file time units.
  localparam u64_t UNIX_EPOCH_100NS = 64'd116444736000000000;

  // Control bits that ride along with an item through the pipeline.
  typedef struct packed {
    logic opcode;  // source of the count
    logic bwd;     // cycle count lies before its start count
    logic pzero;   // performance frequency is zero
  } c2w_ctl_t;

endpackage

// ===== sv/c2w_if.sv =====
// c2w_if: valid/ready channel interfaces of the converter (input items,
// result items, configuration writes). Depends on c2w_pkg.
`timescale 1ns / 1ps

interface c2w_in_if;
  import c2w_pkg::*;
  logic  valid;
  logic  ready;
  logic  opcode;
  u64_t  count_value;
  modport source (output valid, opcode, count_value, input ready);
  modport sink   (input valid, opcode, count_value, output ready);
endinterface

interface c2w_out_if;
  import c2w_pkg::*;
  logic                valid;
  logic                ready;
  u64_t                file_time;
  logic [MILLIS_W-1:0] unix_millis;
  modport source (output valid, file_time, unix_millis, input ready);
  modport sink   (input valid, file_time, unix_millis, output ready);
endinterface

interface c2w_cfg_if;
  import c2w_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/c2w_div_cell.sv =====
// c2w_div_cell: one restoring division step, registered. It takes the next
// dividend bit, produces one quotient bit and passes everything on.
`timescale 1ns / 1ps

module c2w_div_cell #(
  parameter int RW = 40,  // divisor and remainder width
  parameter int QW = 64,  // dividend and quotient width
  parameter int SW = 1    // sideband width
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [QW-1:0] in_nq,
  input  logic [RW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [QW-1:0] out_nq,
  output logic [RW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic          valid_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] nq_r, nq_nxt;
  logic [RW-1:0] div_r;
  logic [SW-1:0] side_r;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  // Shift the next dividend bit into the remainder and try the subtract.
  // Dividend bits leave nq at the top while quotient bits enter at the bottom.
  always_comb begin
    trial   = {in_rem, in_nq[QW-1]};
    diff    = trial - {1'b0, in_div};
    ge      = (trial >= {1'b0, in_div});
    rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
    nq_nxt  = {in_nq[QW-2:0], ge};
  end

  // Valid bit is control state and is cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Payload advances with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      div_r  <= in_div;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_nq    = nq_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

// ===== sv/c2w_div_chain.sv =====
// c2w_div_chain: a row of QW division cells, one quotient bit per cell.
// Depends on c2w_div_cell.
`timescale 1ns / 1ps

module c2w_div_chain #(
  parameter int RW = 40,
  parameter int QW = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [QW-1:0] in_nq,
  input  logic [RW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [QW-1:0] out_nq,
  output logic [RW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic          v_s    [0:QW];
  logic [RW-1:0] rem_s  [0:QW];
  logic [QW-1:0] nq_s   [0:QW];
  logic [RW-1:0] div_s  [0:QW];
  logic [SW-1:0] side_s [0:QW];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = in_rem;
  assign nq_s[0]   = in_nq;
  assign div_s[0]  = in_div;
  assign side_s[0] = in_side;

  // Each cell hands its partial remainder and quotient to the next one.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    c2w_div_cell #(.RW(RW), .QW(QW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_s[i]),
      .in_rem   (rem_s[i]),
      .in_nq    (nq_s[i]),
      .in_div   (div_s[i]),
      .in_side  (side_s[i]),
      .out_valid(v_s[i+1]),
      .out_rem  (rem_s[i+1]),
      .out_nq   (nq_s[i+1]),
      .out_div  (div_s[i+1]),
      .out_side (side_s[i+1])
    );
  end

  assign out_valid = v_s[QW];
  assign out_rem   = rem_s[QW];
  assign out_nq    = nq_s[QW];
  assign out_div   = div_s[QW];
  assign out_side  = side_s[QW];

endmodule

// ===== sv/counter_to_wall_clock_converter.sv =====
// counter_to_wall_clock_converter: top level. Turns performance or cycle
// counter readings into file time and Unix milliseconds.
// Depends on c2w_pkg, c2w_if and c2w_div_chain.
//
//   channel | direction | fields                          | handshake
//   in_chan | input     | opcode, count_value             | valid/ready
//   out_chan| output    | file_time, unix_millis          | valid/ready
//   cfg_chan| input     | reg_index, wdata                | valid/ready, ready tied high
//
// One item is accepted per cycle while the output queue has a free entry. A
// result passes through 1 input stage, 64 cells for count / frequency, 2 multiply
// stages, 24 cells for the fraction, 4 add and compare stages, 3 stages for the
// millisecond reciprocal multiply and 1 output queue stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// The whole pipeline holds only while both entries of the output queue are full.
`timescale 1ns / 1ps

module counter_to_wall_clock_converter #(
  parameter int FREQ_WIDTH = c2w_pkg::FREQ_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  c2w_in_if.sink    in_chan,
  c2w_out_if.source out_chan,
  c2w_cfg_if.sink   cfg_chan
);

  import c2w_pkg::*;

  // Divisor width: wide enough for the frequency and the 3 GHz default.
  localparam int DW     = (FREQ_WIDTH > 32) ? FREQ_WIDTH : 32;
  localparam int HALF   = DW / 2;
  localparam int PW     = DW + SEC_W;
  localparam int WLO_W  = 32 + SEC_W;
  localparam int PLO_W  = HALF + SEC_W;
  localparam int PHI_W  = DW - HALF + SEC_W;
  localparam int CTL_W  = $bits(c2w_ctl_t);
  localparam int SIDE2_W = TIME_W + CTL_W;
  localparam int Q_DEPTH = 2;

  // Widths of the millisecond reciprocal product pieces.
  localparam int MY_W  = TIME_W - MS_PRE_SH;
  localparam int MYH_W = MY_W - 32;
  localparam int MRH_W = MS_RECIP_W - 32;
  localparam int LL_W  = 64;
  localparam int LH_W  = 32 + MRH_W;
  localparam int HL_W  = MYH_W + 32;
  localparam int HH_W  = MYH_W + MRH_W;
  localparam int MID_W = LH_W + 1;
  localparam int T_W   = MID_W + 33;

  // ---------------- configuration registers ----------------
  logic [FREQ_WIDTH-1:0] perf_hz_r;
  logic [FREQ_WIDTH-1:0] cyc_hz_r;
  u64_t                  perf_start_r;
  u64_t                  cyc_start_r;
  u64_t                  base_r;

  assign cfg_chan.ready = 1'b1;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perf_hz_r    <= DEF_PERF_HZ[FREQ_WIDTH-1:0];
      cyc_hz_r     <= DEF_CYCLE_HZ[FREQ_WIDTH-1:0];
      perf_start_r <= DEF_PERF_START;
      cyc_start_r  <= DEF_CYCLE_START;
      base_r       <= DEF_BASE_TIME;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_PERF_HZ:     perf_hz_r    <= cfg_chan.wdata[FREQ_WIDTH-1:0];
        REG_CYCLE_HZ:    cyc_hz_r     <= cfg_chan.wdata[FREQ_WIDTH-1:0];
        REG_PERF_START:  perf_start_r <= cfg_chan.wdata;
        REG_CYCLE_START: cyc_start_r  <= cfg_chan.wdata;
        REG_BASE_TIME:   base_r       <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [1:0] q_cnt_r;
  logic       adv;
  logic       accept;

  // Everything moves while the output queue has a free entry.
  assign adv           = (q_cnt_r != 2'(Q_DEPTH));
  assign in_chan.ready = adv;
  assign accept        = in_chan.valid && adv;

  // ---------------- stage 0: select value and divisor ----------------
  logic [TIME_W:0] cyc_fwd;
  u64_t            cyc_back;
  u64_t            s0_num_nxt;
  logic [DW-1:0]   s0_div_nxt;
  c2w_ctl_t        s0_ctl_nxt;
  logic            s0_v_r;
  u64_t            s0_num_r;
  logic [DW-1:0]   s0_div_r;
  c2w_ctl_t        s0_ctl_r;

  always_comb begin
    cyc_fwd  = {1'b0, in_chan.count_value} - {1'b0, cyc_start_r};
    cyc_back = cyc_start_r - in_chan.count_value;
    s0_ctl_nxt.opcode = in_chan.opcode;
    s0_ctl_nxt.bwd    = (in_chan.opcode == OP_CYCLE) && cyc_fwd[TIME_W];
    s0_ctl_nxt.pzero  = (perf_hz_r == '0);
    if (in_chan.opcode == OP_PERF) begin
      s0_num_nxt = in_chan.count_value;
      s0_div_nxt = DW'(perf_hz_r);
    end else begin
      s0_num_nxt = cyc_fwd[TIME_W] ? cyc_back : cyc_fwd[TIME_W-1:0];
      s0_div_nxt = (cyc_hz_r == '0) ? DEF_CYCLE_HZ[DW-1:0] : DW'(cyc_hz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r <= s0_num_nxt;
      s0_div_r <= s0_div_nxt;
      s0_ctl_r <= s0_ctl_nxt;
    end
  end

  // ---------------- whole seconds: count / frequency ----------------
  logic          c1_v;
  logic [DW-1:0] c1_rem;
  u64_t          c1_quo;
  logic [DW-1:0] c1_div;
  c2w_ctl_t      c1_ctl;

  c2w_div_chain #(.RW(DW), .QW(TIME_W), .SW(CTL_W)) u_sec_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s0_v_r),
    .in_rem   ('0),
    .in_nq    (s0_num_r),
    .in_div   (s0_div_r),
    .in_side  (s0_ctl_r),
    .out_valid(c1_v),
    .out_rem  (c1_rem),
    .out_nq   (c1_quo),
    .out_div  (c1_div),
    .out_side (c1_ctl)
  );

  // ---------------- stage 1: partial products by 10^7 ----------------
  logic             s1_v_r;
  logic [WLO_W-1:0] s1_wlo_r;
  logic [31:0]      s1_whi_r;
  logic [PLO_W-1:0] s1_plo_r;
  logic [PHI_W-1:0] s1_phi_r;
  logic [DW-1:0]    s1_div_r;
  c2w_ctl_t         s1_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wlo_r <= WLO_W'(c1_quo[31:0]) * WLO_W'(TICKS_PER_SEC);
      s1_whi_r <= 32'(c1_quo[63:32]) * 32'(TICKS_PER_SEC);
      s1_plo_r <= PLO_W'(c1_rem[HALF-1:0]) * PLO_W'(TICKS_PER_SEC);
      s1_phi_r <= PHI_W'(c1_rem[DW-1:HALF]) * PHI_W'(TICKS_PER_SEC);
      s1_div_r <= c1_div;
      s1_ctl_r <= c1_ctl;
    end
  end

  // ---------------- stage 2: sum the partial products ----------------
  logic          s2_v_r;
  u64_t          s2_wsc_r;
  logic [PW-1:0] s2_p_r;
  logic [DW-1:0] s2_div_r;
  c2w_ctl_t      s2_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  // The whole part wraps modulo 2^64; the remainder product always fits.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wsc_r <= TIME_W'(s1_wlo_r) + {s1_whi_r, 32'd0};
      s2_p_r   <= PW'(s1_plo_r) + (PW'(s1_phi_r) << HALF);
      s2_div_r <= s1_div_r;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // ---------------- fraction: remainder * 10^7 / frequency ----------------
  // The quotient stays below 10^7, so the top bits start as the remainder.
  logic             c2_v;
  logic [DW-1:0]    c2_rem;
  logic [SEC_W-1:0] c2_frac;
  logic [DW-1:0]    c2_div;
  logic [SIDE2_W-1:0] c2_side;
  u64_t             c2_wsc;
  c2w_ctl_t         c2_ctl;

  c2w_div_chain #(.RW(DW), .QW(SEC_W), .SW(SIDE2_W)) u_frac_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s2_v_r),
    .in_rem   (s2_p_r[PW-1:SEC_W]),
    .in_nq    (s2_p_r[SEC_W-1:0]),
    .in_div   (s2_div_r),
    .in_side  ({s2_wsc_r, s2_ctl_r}),
    .out_valid(c2_v),
    .out_rem  (c2_rem),
    .out_nq   (c2_frac),
    .out_div  (c2_div),
    .out_side (c2_side)
  );

  assign c2_wsc = c2_side[SIDE2_W-1:CTL_W];
  assign c2_ctl = c2_side[CTL_W-1:0];

  // ---------------- stage 3: scaled interval ----------------
  logic     s3_v_r;
  u64_t     s3_int_r;
  c2w_ctl_t s3_ctl_r;
  u64_t     s3_int_nxt;

  // A zero performance frequency gives a zero interval.
  always_comb begin
    if ((c2_ctl.opcode == OP_PERF) && c2_ctl.pzero) begin
      s3_int_nxt = '0;
    end else begin
      s3_int_nxt = c2_wsc + TIME_W'(c2_frac);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_int_r <= s3_int_nxt;
      s3_ctl_r <= c2_ctl;
    end
  end

  // ---------------- stage 4: offset and direction ----------------
  logic s4_v_r;
  logic s4_fwd_r, s4_fwd_nxt;
  u64_t s4_off_r, s4_off_nxt;
  logic perf_ge;

  always_comb begin
    perf_ge = (s3_int_r >= perf_start_r);
    if (s3_ctl_r.opcode == OP_PERF) begin
      s4_fwd_nxt = perf_ge;
      s4_off_nxt = perf_ge ? (s3_int_r - perf_start_r) : (perf_start_r - s3_int_r);
    end else begin
      s4_fwd_nxt = !s3_ctl_r.bwd;
      s4_off_nxt = s3_int_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_fwd_r <= s4_fwd_nxt;
      s4_off_r <= s4_off_nxt;
    end
  end

  // ---------------- stage 5: move the base file time ----------------
  logic s5_v_r;
  u64_t s5_ft_r, s5_ft_nxt;

  // Forward wraps modulo 2^64, backward clamps at zero.
  always_comb begin
    if (s4_fwd_r) begin
      s5_ft_nxt = base_r + s4_off_r;
    end else if (base_r > s4_off_r) begin
      s5_ft_nxt = base_r - s4_off_r;
    end else begin
      s5_ft_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ft_r <= s5_ft_nxt;
    end
  end

  // ---------------- stage 6: time since the Unix epoch ----------------
  logic s6_v_r;
  logic s6_pos_r;
  u64_t s6_x_r;
  u64_t s6_ft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_pos_r <= (s5_ft_r > UNIX_EPOCH_100NS);
      s6_x_r   <= s5_ft_r - UNIX_EPOCH_100NS;
      s6_ft_r  <= s5_ft_r;
    end
  end

  // ---------------- milliseconds: multiply by the reciprocal of 10^4 ----------------
  // The time since the epoch drops its low bits, is multiplied by MS_RECIP and
  // the top of the product is the millisecond count. The product is built from
  // four pieces of at most 32 by 32 bits and summed over two stages.
  logic [MY_W-1:0]     ms_y;
  logic                s7_v_r;
  logic [LL_W-1:0]     s7_ll_r;
  logic [LH_W-1:0]     s7_lh_r;
  logic [HL_W-1:0]     s7_hl_r;
  logic [HH_W-1:0]     s7_hh_r;
  u64_t                s7_ft_r;
  logic                s7_pos_r;
  logic                s8_v_r;
  logic [MID_W-1:0]    s8_mid_r;
  logic [LL_W-1:0]     s8_ll_r;
  logic [HH_W-1:0]     s8_hh_r;
  u64_t                s8_ft_r;
  logic                s8_pos_r;
  logic                s9_v_r;
  logic [T_W-1:0]      s9_t_r;
  logic [HH_W-1:0]     s9_hh_r;
  u64_t                s9_ft_r;
  logic                s9_pos_r;
  logic [HH_W-1:0]     ms_sum;
  logic [MILLIS_W-1:0] ms_val;

  assign ms_y = s6_x_r[TIME_W-1:MS_PRE_SH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      s9_v_r <= s8_v_r;
    end
  end

  // Stage 7 forms the four partial products, stage 8 adds the two middle
  // ones, stage 9 adds the low one; the high one joins at the queue write.
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ll_r  <= LL_W'(ms_y[31:0]) * LL_W'(MS_RECIP[31:0]);
      s7_lh_r  <= LH_W'(ms_y[31:0]) * LH_W'(MS_RECIP[MS_RECIP_W-1:32]);
      s7_hl_r  <= HL_W'(ms_y[MY_W-1:32]) * HL_W'(MS_RECIP[31:0]);
      s7_hh_r  <= HH_W'(ms_y[MY_W-1:32]) * HH_W'(MS_RECIP[MS_RECIP_W-1:32]);
      s7_ft_r  <= s6_ft_r;
      s7_pos_r <= s6_pos_r;
      s8_mid_r <= MID_W'(s7_lh_r) + MID_W'(s7_hl_r);
      s8_ll_r  <= s7_ll_r;
      s8_hh_r  <= s7_hh_r;
      s8_ft_r  <= s7_ft_r;
      s8_pos_r <= s7_pos_r;
      s9_t_r   <= T_W'(s8_ll_r) + {1'b0, s8_mid_r, 32'd0};
      s9_hh_r  <= s8_hh_r;
      s9_ft_r  <= s8_ft_r;
      s9_pos_r <= s8_pos_r;
    end
  end

  // Only the bits above 2^64 of the full product are needed.
  assign ms_sum = HH_W'(s9_t_r[T_W-1:TIME_W]) + s9_hh_r;
  assign ms_val = ms_sum[MS_POST_SH-TIME_W +: MILLIS_W];

  // ---------------- output queue ----------------
  u64_t                q_ft_r [0:Q_DEPTH-1];
  logic [MILLIS_W-1:0] q_ms_r [0:Q_DEPTH-1];
  logic                q_wr_r;
  logic                q_rd_r;
  logic                push;
  logic                pop;

  assign push = s9_v_r && adv;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
      if (push) begin
        q_wr_r <= !q_wr_r;
      end
      if (pop) begin
        q_rd_r <= !q_rd_r;
      end
    end
  end

  // Milliseconds read zero at or before the epoch.
  always_ff @(posedge clk) begin
    if (push) begin
      q_ft_r[q_wr_r] <= s9_ft_r;
      q_ms_r[q_wr_r] <= s9_pos_r ? ms_val : '0;
    end
  end

  assign out_chan.valid       = (q_cnt_r != '0);
  assign out_chan.file_time   = q_ft_r[q_rd_r];
  assign out_chan.unix_millis = q_ms_r[q_rd_r];

endmodule
